### rtl/iol_pkg.sv
// Shared constants, codes and types of the indexed ordered list.
package iol_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int OCNT_W = 5;
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT = 3'd0,
        OP_REM_FRONT = 3'd1,
        OP_ADD_BACK  = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_INS_AT    = 3'd4,
        OP_REM_AT    = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage

### rtl/iol_req_if.sv
// Request channel of the indexed ordered list.
interface iol_req_if;
    logic                       valid;
    logic                       ready;
    logic [iol_pkg::OP_W-1:0]   op;
    logic [iol_pkg::POS_W-1:0]  position;
    logic [iol_pkg::VAL_W-1:0]  value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

### rtl/iol_rsp_if.sv
// Result channel of the indexed ordered list.
interface iol_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [iol_pkg::VAL_W-1:0]   removed_value;
    logic [iol_pkg::STAT_W-1:0]  status;
    logic [iol_pkg::OCNT_W-1:0]  count;

    modport source (output valid, output removed_value, output status, output count,
                    input ready);
    modport sink   (input valid, input removed_value, input status, input count,
                    output ready);
endinterface

### rtl/indexed_ordered_list.sv
// Top level of the indexed ordered list: request sequencer around the entry RAM.
//
// Each request word on req asks for one of six operations on an ordered list of
// up to CAPACITY data words: add or remove at the front, at the back, or at a
// given position. Every request yields exactly one result word on rsp carrying
// the removed data word (zero unless a removal succeeded), a status code and
// the new entry count.
// The entries live in a single RAM with one write and one registered read port.
// Inserting or removing in the middle moves every entry behind the position by
// one place, one entry per cycle, reading the next entry while writing the last.
// A failed request or an unused op code goes from S_IDLE straight to S_DONE,
// where its result is registered. An insert moves the m entries up one place
// and then writes the new word; a removal captures the removed word in
// S_REM_CAP and then moves the m entries down one place. Here m is the number
// of entries moved (0 at the back, up to CAPACITY - 1 at the front). One
// request is processed at a time. The next request is accepted in the cycle
// after the previous result is registered, even while it still waits on rsp.
// If the receiver stalls, the block holds the result and finishes at most one
// further request before it waits for the result register to drain.
// Reset empties the list at once; the RAM contents need no clearing.
module indexed_ordered_list (
    input  logic      clk,
    input  logic      rst_n,
    iol_req_if.sink   req,
    iol_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_REM_CAP,
        S_REM,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [iol_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [iol_pkg::IDX_W-1:0]       cur_reg, cur_next;
    logic [iol_pkg::IDX_W-1:0]       pos_reg, pos_next;
    logic [iol_pkg::DATA_WIDTH-1:0]  value_reg, value_next;
    logic [iol_pkg::DATA_WIDTH-1:0]  removed_reg, removed_next;
    iol_pkg::status_t                status_reg, status_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [iol_pkg::IDX_W-1:0]       pend_addr_reg, pend_addr_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [iol_pkg::VAL_W-1:0]       rsp_removed_reg, rsp_removed_next;
    logic [iol_pkg::STAT_W-1:0]      rsp_status_reg, rsp_status_next;
    logic [iol_pkg::OCNT_W-1:0]      rsp_count_reg, rsp_count_next;

    logic                            ram_we;
    logic [iol_pkg::IDX_W-1:0]       ram_waddr;
    logic [iol_pkg::DATA_WIDTH-1:0]  ram_wdata;
    logic [iol_pkg::IDX_W-1:0]       ram_raddr;
    logic [iol_pkg::DATA_WIDTH-1:0]  ram_rdata;

    logic                            is_ins;
    logic                            is_rem;
    logic                            need_entry;
    logic [iol_pkg::CMP_W-1:0]       pos_eff;
    logic [iol_pkg::CMP_W-1:0]       cnt_ext;
    iol_pkg::status_t                st;

    iol_ram #(
        .WIDTH (iol_pkg::DATA_WIDTH),
        .DEPTH (iol_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.removed_value = rsp_removed_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.count         = rsp_count_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        cur_next         = cur_reg;
        pos_next         = pos_reg;
        value_next       = value_reg;
        removed_next     = removed_reg;
        status_next      = status_reg;
        pend_valid_next  = pend_valid_reg;
        pend_addr_next   = pend_addr_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_removed_next = rsp_removed_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_count_next   = rsp_count_reg;

        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = cur_reg;

        is_ins     = 1'b0;
        is_rem     = 1'b0;
        need_entry = 1'b0;
        pos_eff    = '0;
        cnt_ext    = iol_pkg::CMP_W'(count_reg);
        st         = iol_pkg::ST_OK;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (iol_pkg::op_t'(req.op))
            iol_pkg::OP_ADD_FRONT:
            begin
                is_ins  = 1'b1;
                pos_eff = '0;
            end
            iol_pkg::OP_ADD_BACK:
            begin
                is_ins  = 1'b1;
                pos_eff = cnt_ext;
            end
            iol_pkg::OP_INS_AT:
            begin
                is_ins  = 1'b1;
                pos_eff = iol_pkg::CMP_W'(req.position);
            end
            iol_pkg::OP_REM_FRONT:
            begin
                is_rem     = 1'b1;
                need_entry = 1'b1;
                pos_eff    = '0;
            end
            iol_pkg::OP_REM_BACK:
            begin
                is_rem     = 1'b1;
                need_entry = 1'b1;
                pos_eff    = cnt_ext - iol_pkg::CMP_W'(1);
            end
            iol_pkg::OP_REM_AT:
            begin
                is_rem  = 1'b1;
                pos_eff = iol_pkg::CMP_W'(req.position);
            end
            default:
            begin
                is_ins = 1'b0;
            end
        endcase

        if (is_rem)
        begin
            if (need_entry && (cnt_ext == '0))
            begin
                st = iol_pkg::ST_EMPTY;
            end
            else if (pos_eff >= cnt_ext)
            begin
                st = iol_pkg::ST_RANGE;
            end
        end
        else if (is_ins)
        begin
            if (pos_eff > cnt_ext)
            begin
                st = iol_pkg::ST_RANGE;
            end
            else if (count_reg == iol_pkg::CNT_W'(iol_pkg::CAPACITY))
            begin
                st = iol_pkg::ST_FULL;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    removed_next    = '0;
                    status_next     = st;
                    value_next      = iol_pkg::DATA_WIDTH'(req.value);
                    pos_next        = iol_pkg::IDX_W'(pos_eff);
                    pend_valid_next = 1'b0;
                    if (is_ins && (st == iol_pkg::ST_OK))
                    begin
                        cur_next   = iol_pkg::IDX_W'(count_reg);
                        state_next = S_INS;
                    end
                    else if (is_rem && (st == iol_pkg::ST_OK))
                    begin
                        ram_raddr  = iol_pkg::IDX_W'(pos_eff);
                        cur_next   = iol_pkg::IDX_W'(pos_eff);
                        state_next = S_REM_CAP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_INS:
            begin
                if (pend_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (cur_reg != pos_reg)
                begin
                    ram_raddr       = cur_reg - iol_pkg::IDX_W'(1);
                    pend_addr_next  = cur_reg;
                    pend_valid_next = 1'b1;
                    cur_next        = cur_reg - iol_pkg::IDX_W'(1);
                end
                else if (!pend_valid_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = value_reg;
                    count_next = count_reg + iol_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    pend_valid_next = 1'b0;
                end
            end
            S_REM_CAP:
            begin
                removed_next = ram_rdata;
                state_next   = S_REM;
            end
            S_REM:
            begin
                if (pend_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if ((iol_pkg::CNT_W'(cur_reg) + iol_pkg::CNT_W'(1)) < count_reg)
                begin
                    ram_raddr       = cur_reg + iol_pkg::IDX_W'(1);
                    pend_addr_next  = cur_reg;
                    pend_valid_next = 1'b1;
                    cur_next        = cur_reg + iol_pkg::IDX_W'(1);
                end
                else if (!pend_valid_reg)
                begin
                    count_next = count_reg - iol_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    pend_valid_next = 1'b0;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_removed_next = iol_pkg::VAL_W'(removed_reg);
                    rsp_status_next  = status_reg;
                    rsp_count_next   = iol_pkg::OCNT_W'(count_reg);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            cur_reg         <= '0;
            pos_reg         <= '0;
            value_reg       <= '0;
            removed_reg     <= '0;
            status_reg      <= iol_pkg::ST_OK;
            pend_addr_reg   <= '0;
            rsp_removed_reg <= '0;
            rsp_status_reg  <= '0;
            rsp_count_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            pend_valid_reg  <= pend_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            cur_reg         <= cur_next;
            pos_reg         <= pos_next;
            value_reg       <= value_next;
            removed_reg     <= removed_next;
            status_reg      <= status_next;
            pend_addr_reg   <= pend_addr_next;
            rsp_removed_reg <= rsp_removed_next;
            rsp_status_reg  <= rsp_status_next;
            rsp_count_reg   <= rsp_count_next;
        end
    end

endmodule

### rtl/iol_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module iol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### bench/tb.sv
// Testbench of the indexed ordered list: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    iol_req_if req ();
    iol_rsp_if rsp ();

    indexed_ordered_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    typedef struct packed {
        logic [iol_pkg::VAL_W-1:0]  removed_value;
        iol_pkg::status_t           status;
        logic [iol_pkg::OCNT_W-1:0] count;
    } result_t;

    localparam int CYCLE_LIMIT = 400000;

    logic [iol_pkg::DATA_WIDTH-1:0] list_words [$];
    result_t                        pending_results [$];
    int                             mismatch_count = 0;
    int                             cycle_count = 0;
    int                             send_idle_pct = 0;
    int                             recv_stall_pct = 0;

    always #10 clk = ~clk;

    function automatic result_t predict_request(logic [iol_pkg::OP_W-1:0] op,
                                                logic [iol_pkg::POS_W-1:0] pos,
                                                logic [iol_pkg::VAL_W-1:0] value);
        result_t r;
        int n;
        n = list_words.size();
        r.removed_value = '0;
        r.status = iol_pkg::ST_OK;
        case (op) inside
            iol_pkg::OP_ADD_FRONT, iol_pkg::OP_ADD_BACK, iol_pkg::OP_INS_AT:
            begin
                int at;
                at = (op == iol_pkg::OP_ADD_FRONT) ? 0 :
                     (op == iol_pkg::OP_ADD_BACK) ? n : int'(pos);
                if (at > n)
                    r.status = iol_pkg::ST_RANGE;
                else if (n >= iol_pkg::CAPACITY)
                    r.status = iol_pkg::ST_FULL;
                else
                    list_words.insert(at, value[iol_pkg::DATA_WIDTH-1:0]);
            end
            iol_pkg::OP_REM_FRONT, iol_pkg::OP_REM_BACK, iol_pkg::OP_REM_AT:
            begin
                int at;
                at = (op == iol_pkg::OP_REM_FRONT) ? 0 :
                     (op == iol_pkg::OP_REM_BACK) ? n - 1 : int'(pos);
                if (op != iol_pkg::OP_REM_AT && n == 0)
                    r.status = iol_pkg::ST_EMPTY;
                else if (at >= n)
                    r.status = iol_pkg::ST_RANGE;
                else
                begin
                    r.removed_value = iol_pkg::VAL_W'(list_words[at]);
                    list_words.delete(at);
                end
            end
            default:
            begin
            end
        endcase
        r.count = iol_pkg::OCNT_W'(list_words.size());
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(logic [iol_pkg::OP_W-1:0] op, logic [iol_pkg::POS_W-1:0] pos,
                                logic [iol_pkg::VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.position <= pos;
        req.value <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_results.push_back(predict_request(op, pos, value));
        @(negedge clk);
    endtask

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", 32'(rsp.status), 32'd0);
            else
            begin
                result_t e;
                e = pending_results.pop_front();
                if (rsp.removed_value !== e.removed_value)
                    report_mismatch("removed_value", rsp.removed_value, e.removed_value);
                if (rsp.status !== e.status)
                    report_mismatch("status", 32'(rsp.status), 32'(e.status));
                if (rsp.count !== e.count)
                    report_mismatch("count", 32'(rsp.count), 32'(e.count));
            end
        end
    end

    task automatic test_directed();
        send_request(iol_pkg::OP_REM_FRONT, 5'd0, 32'h0);
        send_request(iol_pkg::OP_REM_BACK, 5'd0, 32'h0);
        send_request(iol_pkg::OP_REM_AT, 5'd0, 32'h0);
        send_request(iol_pkg::OP_INS_AT, 5'd1, 32'h1234);
        send_request(iol_pkg::OP_INS_AT, 5'd31, 32'hFFFF_FFFF);
        send_request(iol_pkg::OP_ADD_FRONT, 5'd0, 32'hFFFF_FFFF);
        send_request(iol_pkg::OP_ADD_BACK, 5'h1F, 32'h0);
        send_request(iol_pkg::OP_INS_AT, 5'd1, 32'hA5A5_5A5A);
        send_request(3'd6, 5'h1F, 32'hFFFF_FFFF);
        send_request(3'd7, 5'd0, 32'h5A5A_A5A5);
        for (int i = 0; i < 14; i++)
            send_request(iol_pkg::OP_ADD_BACK, 5'd0, 32'h100 + i);
        send_request(iol_pkg::OP_ADD_FRONT, 5'd0, 32'hDEAD);
        send_request(iol_pkg::OP_INS_AT, 5'd16, 32'hBEEF);
        send_request(iol_pkg::OP_INS_AT, 5'd17, 32'hBEEF);
        send_request(iol_pkg::OP_REM_AT, 5'd16, 32'h0);
        send_request(iol_pkg::OP_REM_AT, 5'd15, 32'h0);
        send_request(iol_pkg::OP_REM_AT, 5'd0, 32'h0);
    endtask

    task automatic test_random(int items);
        for (int i = 0; i < items; i++)
        begin
            logic [iol_pkg::OP_W-1:0] op;
            logic [iol_pkg::POS_W-1:0] pos;
            int n;
            n = list_words.size();
            op = ($urandom_range(99) < 4) ? iol_pkg::OP_W'($urandom_range(7, 6))
                                          : iol_pkg::OP_W'($urandom_range(5));
            if (n < 4 && op inside {iol_pkg::OP_REM_FRONT, iol_pkg::OP_REM_BACK,
                                    iol_pkg::OP_REM_AT}
                && $urandom_range(1))
                op = iol_pkg::OP_ADD_BACK;
            if (n > 13 && op inside {iol_pkg::OP_ADD_FRONT, iol_pkg::OP_ADD_BACK,
                                     iol_pkg::OP_INS_AT}
                && $urandom_range(1))
                op = iol_pkg::OP_REM_AT;
            if ($urandom_range(9) == 0)
                pos = iol_pkg::POS_W'($urandom);
            else
                pos = iol_pkg::POS_W'($urandom_range(n));
            send_request(op, pos, $urandom);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.op = '0;
        req.position = '0;
        req.value = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        drain();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(225);
        send_idle_pct = 77; recv_stall_pct = 0;  test_random(225);
        send_idle_pct = 0;  recv_stall_pct = 77; test_random(225);
        send_idle_pct = 31; recv_stall_pct = 31; test_random(225);
        drain();
        if (pending_results.size() == 0 && mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### indexed_ordered_list.f
rtl/iol_pkg.sv
rtl/iol_req_if.sv
rtl/iol_rsp_if.sv
rtl/iol_ram.sv
rtl/indexed_ordered_list.sv
bench/tb.sv
